>>> sv/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared constants, report codes and bracket decoding for the bracket
// balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  // Default number of stack entries.
  localparam int unsigned BBC_STACK_DEPTH = 32;

  // Report codes carried in report_kind.
  localparam logic [2:0] KIND_UNMATCHED = 3'd0;
  localparam logic [2:0] KIND_MISMATCH  = 3'd1;
  localparam logic [2:0] KIND_UNCLOSED  = 3'd2;
  localparam logic [2:0] KIND_OVERFLOW  = 3'd3;
  localparam logic [2:0] KIND_SUMMARY   = 3'd4;

  // Character codes.
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_BRACE_O  = 8'h7B;
  localparam logic [7:0] CHAR_PAREN_O  = 8'h28;
  localparam logic [7:0] CHAR_SQUARE_O = 8'h5B;
  localparam logic [7:0] CHAR_BRACE_C  = 8'h7D;
  localparam logic [7:0] CHAR_PAREN_C  = 8'h29;
  localparam logic [7:0] CHAR_SQUARE_C = 8'h5D;

  // Bracket types as stored on the stack.
  localparam logic [1:0] BR_BRACE  = 2'd0;
  localparam logic [1:0] BR_PAREN  = 2'd1;
  localparam logic [1:0] BR_SQUARE = 2'd2;

  // Decoded view of one text byte.
  typedef struct packed {
    logic       is_open;
    logic       is_close;
    logic [1:0] btype;
  } bracket_t;

  function automatic bracket_t bracket_decode(input logic [7:0] c);
    bracket_t b;
    b = '{is_open: 1'b0, is_close: 1'b0, btype: BR_BRACE};
    case (c)
      CHAR_BRACE_O:  b = '{is_open: 1'b1, is_close: 1'b0, btype: BR_BRACE};
      CHAR_PAREN_O:  b = '{is_open: 1'b1, is_close: 1'b0, btype: BR_PAREN};
      CHAR_SQUARE_O: b = '{is_open: 1'b1, is_close: 1'b0, btype: BR_SQUARE};
      CHAR_BRACE_C:  b = '{is_open: 1'b0, is_close: 1'b1, btype: BR_BRACE};
      CHAR_PAREN_C:  b = '{is_open: 1'b0, is_close: 1'b1, btype: BR_PAREN};
      CHAR_SQUARE_C: b = '{is_open: 1'b0, is_close: 1'b1, btype: BR_SQUARE};
      default:       b = '{is_open: 1'b0, is_close: 1'b0, btype: BR_BRACE};
    endcase
    return b;
  endfunction

  // Opening character for a stored bracket type.
  function automatic logic [7:0] open_char(input logic [1:0] t);
    logic [7:0] c;
    case (t)
      BR_PAREN:  c = CHAR_PAREN_O;
      BR_SQUARE: c = CHAR_SQUARE_O;
      default:   c = CHAR_BRACE_O;
    endcase
    return c;
  endfunction

endpackage

>>> sv/bbc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_in_if
// Input channel: one text byte or an end-of-text mark per beat.
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

>>> sv/bbc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_out_if
// Output channel: one report per beat.
// ----------------------------------------------------------------------------
interface bbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  report_kind;
  logic [7:0]  bracket_byte;
  logic [15:0] line_index;
  logic        any_error;
  logic        last_report;

  modport source (output valid, output report_kind, output bracket_byte,
                  output line_index, output any_error, output last_report,
                  input ready);
  modport sink   (input valid, input report_kind, input bracket_byte,
                  input line_index, input any_error, input last_report,
                  output ready);
endinterface

>>> sv/bracket_balance_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_top
// Checks bracket nesting over a byte stream with a bounded stack held in a
// synchronous memory, and reports errors, with line numbers bar unclosed ones.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  in_i     sink       char_code, end_of_text
//  out_o    source     report_kind, bracket_byte, line_index, any_error,
//                      last_report
//
//  A plain byte, newline or opening bracket is handled in the idle state;
//  a closing bracket on a non-empty stack reads the stack memory there and
//  is checked against the read data in the check state. End of text with
//  an empty stack gives the summary at once; otherwise the flush state
//  gives one unclosed report per memory read, then the summary follows.
//  Reset clears the count, line and error flag at once; there is no sweep.
//  A report waits in the output register while out_o.ready is low; the
//  next beat is taken as soon as that register frees and the state is idle.
// ----------------------------------------------------------------------------
module bracket_balance_checker_top
  import bbc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = BBC_STACK_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbc_in_if.sink     in_i,
  bbc_out_if.source  out_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FLUSH,
    ST_SUMMARY
  } state_e;

  // Control and payload registers.
  state_e      state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0] line_q, line_d;
  logic        err_q, err_d;
  logic        any_q, any_d;
  logic [1:0]  cls_type_q, cls_type_d;
  logic [7:0]  cls_byte_q, cls_byte_d;

  logic        out_vld_q, out_vld_d;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [15:0] lidx_q, lidx_d;
  logic        oany_q, oany_d;
  logic        last_q, last_d;

  // Stack memory ports.
  logic [1:0]  stack_mem [STACK_DEPTH];
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [1:0]  mem_wdata, rd_q;

  logic        out_free, in_ready, accept, emit;
  logic [CW-1:0] count_dec;
  bracket_t    br;

  assign out_free  = !out_vld_q || out_o.ready;
  assign in_ready  = (state_q == ST_IDLE) && out_free;
  assign accept    = in_i.valid && in_ready;
  assign count_dec = count_q - CW'(1);
  assign br        = bracket_decode(in_i.char_code);

  // Next-state logic for the sequencer and the output register.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    line_d     = line_q;
    err_d      = err_q;
    any_d      = any_q;
    cls_type_d = cls_type_q;
    cls_byte_d = cls_byte_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = count_q[AW-1:0];
    mem_raddr  = count_dec[AW-1:0];
    mem_wdata  = br.btype;
    emit       = 1'b0;
    kind_d     = kind_q;
    byte_d     = byte_q;
    lidx_d     = lidx_q;
    oany_d     = oany_q;
    last_d     = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.end_of_text) begin
            any_d = err_q || (count_q != '0);
            if (count_q != '0) begin
              mem_re  = 1'b1;
              count_d = count_dec;
              state_d = ST_FLUSH;
            end else begin
              emit   = 1'b1;
              kind_d = KIND_SUMMARY;
              byte_d = '0;
              lidx_d = '0;
              oany_d = err_q;
              last_d = 1'b1;
              line_d = 16'd1;
              err_d  = 1'b0;
            end
          end else if (in_i.char_code == CHAR_LF) begin
            if (line_q != 16'hFFFF) begin
              line_d = line_q + 16'd1;
            end
          end else if (br.is_open) begin
            if (count_q < CW'(STACK_DEPTH)) begin
              mem_we  = 1'b1;
              count_d = count_q + CW'(1);
            end else begin
              emit   = 1'b1;
              kind_d = KIND_OVERFLOW;
              byte_d = in_i.char_code;
              lidx_d = line_q;
              oany_d = 1'b0;
              last_d = 1'b1;
              err_d  = 1'b1;
            end
          end else if (br.is_close) begin
            if (count_q == '0) begin
              emit   = 1'b1;
              kind_d = KIND_UNMATCHED;
              byte_d = in_i.char_code;
              lidx_d = line_q;
              oany_d = 1'b0;
              last_d = 1'b1;
              err_d  = 1'b1;
            end else begin
              mem_re     = 1'b1;
              count_d    = count_dec;
              cls_type_d = br.btype;
              cls_byte_d = in_i.char_code;
              state_d    = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        // The popped opener is in the read register now.
        if (rd_q == cls_type_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          emit    = 1'b1;
          kind_d  = KIND_MISMATCH;
          byte_d  = cls_byte_q;
          lidx_d  = line_q;
          oany_d  = 1'b0;
          last_d  = 1'b1;
          err_d   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        // One unclosed report per entry; fetch the next entry meanwhile.
        if (out_free) begin
          emit   = 1'b1;
          kind_d = KIND_UNCLOSED;
          byte_d = open_char(rd_q);
          lidx_d = '0;
          oany_d = 1'b0;
          last_d = 1'b0;
          if (count_q != '0) begin
            mem_re  = 1'b1;
            count_d = count_dec;
          end else begin
            state_d = ST_SUMMARY;
          end
        end
      end
      ST_SUMMARY: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = KIND_SUMMARY;
          byte_d  = '0;
          lidx_d  = '0;
          oany_d  = any_q;
          last_d  = 1'b1;
          line_d  = 16'd1;
          err_d   = 1'b0;
          count_d = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // Sequencer state, count, line, error flag and output valid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      line_q    <= 16'd1;
      err_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      line_q    <= line_d;
      err_q     <= err_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    any_q      <= any_d;
    cls_type_q <= cls_type_d;
    cls_byte_q <= cls_byte_d;
    kind_q     <= kind_d;
    byte_q     <= byte_d;
    lidx_q     <= lidx_d;
    oany_q     <= oany_d;
    last_q     <= last_d;
  end

  // Stack memory: one write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= stack_mem[mem_raddr];
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_vld_q;
  assign out_o.report_kind  = kind_q;
  assign out_o.bracket_byte = byte_q;
  assign out_o.line_index   = lidx_q;
  assign out_o.any_error    = oany_q;
  assign out_o.last_report  = last_q;

  // The stack count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  // A new report is only loaded into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("report loaded over a pending one");

  // Memory reads and writes never collide in one cycle.
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("stack read and write in the same cycle");

  // A summary leaves the checker in its reset state.
  a_summary_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && kind_d == KIND_SUMMARY) |=> (count_q == '0 && line_q == 16'd1 && !err_q))
    else $error("state not cleared after summary");

  // No input beat is taken while the sequencer is out of its idle state.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready)
    else $error("input taken while busy");

endmodule

>>> dv/bracket_balance_checker_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_top_tb
// Self-checking bench for the bracket balance checker. A tracker class keeps
// its own copy of the bracket stack, line counter and error flag, predicts
// the reports for every accepted input beat and compares each report beat
// against the oldest prediction. Stimulus is a short directed run, then
// random texts: mostly well-formed nesting, plus broken texts, deep texts
// that can overflow the stack, and raw noise.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module bracket_balance_checker_top_tb;
  import bbc_pkg::*;

  localparam int unsigned DEPTH       = BBC_STACK_DEPTH;
  localparam int unsigned ITEM_TARGET = 410;
  localparam int unsigned ITEM_MARGIN = 60;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned TAIL_CYCLES = DEPTH + 8;

  // Kinds of random text the generator produces.
  typedef enum int unsigned {
    TEXT_CLEAN,
    TEXT_BROKEN,
    TEXT_DEEP,
    TEXT_NOISE
  } text_flavor_e;

  // One report beat as it leaves the block.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  bracket;
    logic [15:0] line;
    logic        any_err;
    logic        last;
  } report_t;

  // Tracks nesting state and holds the reports still owed by the block.
  class nesting_tracker;
    logic [1:0]  stack_mem [DEPTH];
    int unsigned depth_now;
    logic [15:0] line_now;
    logic        err_seen;
    report_t     owed_reports [$];
    int unsigned failures;

    function new();
      depth_now = 0;
      line_now  = 16'd1;
      err_seen  = 1'b0;
      failures  = 0;
    endfunction

    static function logic [7:0] open_byte(input logic [1:0] t);
      logic [7:0] c;
      case (t)
        BR_PAREN:  c = CHAR_PAREN_O;
        BR_SQUARE: c = CHAR_SQUARE_O;
        default:   c = CHAR_BRACE_O;
      endcase
      return c;
    endfunction

    static function logic [7:0] close_byte(input logic [1:0] t);
      logic [7:0] c;
      case (t)
        BR_PAREN:  c = CHAR_PAREN_C;
        BR_SQUARE: c = CHAR_SQUARE_C;
        default:   c = CHAR_BRACE_C;
      endcase
      return c;
    endfunction

    function void owe(input logic [2:0] kind, input logic [7:0] br,
                      input logic [15:0] line, input logic any_err);
      report_t r;
      r = '{kind: kind, bracket: br, line: line, any_err: any_err, last: 1'b0};
      owed_reports.push_back(r);
    endfunction

    // Advances the state by one accepted input beat.
    function void take_char(input logic [7:0] c, input logic eot);
      int unsigned before_cnt;
      logic        flag;
      logic [1:0]  t;
      before_cnt = owed_reports.size();
      if (eot) begin
        flag = err_seen || (depth_now != 0);
        while (depth_now > 0) begin
          depth_now--;
          owe(KIND_UNCLOSED, open_byte(stack_mem[depth_now]), 16'd0, 1'b0);
        end
        owe(KIND_SUMMARY, 8'd0, 16'd0, flag);
        line_now = 16'd1;
        err_seen = 1'b0;
      end else begin
        case (c)
          CHAR_LF: begin
            if (line_now != 16'hFFFF) line_now++;
          end
          CHAR_BRACE_O, CHAR_PAREN_O, CHAR_SQUARE_O: begin
            t = (c == CHAR_PAREN_O) ? BR_PAREN :
                (c == CHAR_SQUARE_O) ? BR_SQUARE : BR_BRACE;
            if (depth_now < DEPTH) begin
              stack_mem[depth_now] = t;
              depth_now++;
            end else begin
              owe(KIND_OVERFLOW, c, line_now, 1'b0);
              err_seen = 1'b1;
            end
          end
          CHAR_BRACE_C, CHAR_PAREN_C, CHAR_SQUARE_C: begin
            t = (c == CHAR_PAREN_C) ? BR_PAREN :
                (c == CHAR_SQUARE_C) ? BR_SQUARE : BR_BRACE;
            if (depth_now == 0) begin
              owe(KIND_UNMATCHED, c, line_now, 1'b0);
              err_seen = 1'b1;
            end else begin
              depth_now--;
              if (stack_mem[depth_now] != t) begin
                owe(KIND_MISMATCH, c, line_now, 1'b0);
                err_seen = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      // The final report of this beat carries the last flag.
      if (owed_reports.size() > before_cnt)
        owed_reports[owed_reports.size() - 1].last = 1'b1;
    endfunction

    // Compares one report beat against the oldest owed report.
    function void match_report(input report_t got);
      report_t want;
      if (owed_reports.size() == 0) begin
        $error("unexpected report: kind %0d byte %0d line %0d", got.kind, got.bracket,
               got.line);
        failures++;
        return;
      end
      want = owed_reports.pop_front();
      if (got.kind !== want.kind) begin
        $error("report_kind: expected %0d, actual %0d", want.kind, got.kind);
        failures++;
      end
      if (got.bracket !== want.bracket) begin
        $error("bracket_byte: expected %0d, actual %0d", want.bracket, got.bracket);
        failures++;
      end
      if (got.line !== want.line) begin
        $error("line_index: expected %0d, actual %0d", want.line, got.line);
        failures++;
      end
      if (got.any_err !== want.any_err) begin
        $error("any_error: expected %0d, actual %0d", want.any_err, got.any_err);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last_report: expected %0d, actual %0d", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bbc_in_if  in_if ();
  bbc_out_if out_if ();

  bracket_balance_checker_top #(
    .STACK_DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  nesting_tracker tracker;
  int unsigned    items_counted;
  int unsigned    burst_left;
  int unsigned    cycle_count;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bracket_balance_checker_top test failed");
      $finish;
    end
  end

  // Check every accepted report beat.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      tracker.match_report('{kind: out_if.report_kind, bracket: out_if.bracket_byte,
                             line: out_if.line_index, any_err: out_if.any_error,
                             last: out_if.last_report});
  end

  // Receiver: stretches of full speed, coin-flip ready and long stalls.
  initial begin
    int unsigned mode;
    int unsigned span;
    out_if.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(4, 40);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       out_if.ready = 1'b1;
          1:       out_if.ready = 1'($urandom_range(0, 1));
          default: out_if.ready = ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  function automatic bit is_special(input logic [7:0] c);
    return c == CHAR_LF || c == CHAR_BRACE_O || c == CHAR_PAREN_O ||
           c == CHAR_SQUARE_O || c == CHAR_BRACE_C || c == CHAR_PAREN_C ||
           c == CHAR_SQUARE_C;
  endfunction

  // Sends one beat, then maybe opens a gap at the end of a burst.
  task automatic push_char(input logic [7:0] c, input logic eot);
    in_if.valid       = 1'b1;
    in_if.char_code   = c;
    in_if.end_of_text = eot;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    tracker.take_char(c, eot);
    items_counted++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  // Holds the sender off until every owed report has come back.
  task automatic wait_drain();
    in_if.valid = 1'b0;
    while (tracker.owed_reports.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_special(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Produces one random text terminated by an end-of-text beat.
  task automatic gen_text(input text_flavor_e flavor);
    logic [1:0]  opened [$];
    int unsigned len;
    int unsigned cap;
    int unsigned pick;
    int unsigned tv;
    logic [1:0]  t;
    len = $urandom_range(4, 40);
    cap = $urandom_range(1, 12);
    if (flavor == TEXT_DEEP) begin
      cap = DEPTH + 10;
      repeat ($urandom_range(DEPTH - 2, DEPTH + 8)) begin
        t = 2'($urandom_range(0, 2));
        opened.push_back(t);
        push_char(nesting_tracker::open_byte(t), 1'b0);
      end
    end
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (flavor == TEXT_NOISE) begin
        push_char(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 40 && opened.size() < cap) begin
        t = 2'($urandom_range(0, 2));
        opened.push_back(t);
        push_char(nesting_tracker::open_byte(t), 1'b0);
      end else if (pick < 70 && opened.size() > 0) begin
        t = opened[opened.size() - 1];
        opened.delete(opened.size() - 1);
        if (flavor == TEXT_BROKEN && $urandom_range(0, 4) == 0) begin
          tv = (int'(t) + 1 + $urandom_range(0, 1)) % 3;
          t  = tv[1:0];
        end
        push_char(nesting_tracker::close_byte(t), 1'b0);
      end else if (pick < 80) begin
        push_char(CHAR_LF, 1'b0);
      end else if (pick < 90 || flavor != TEXT_BROKEN) begin
        push_char(filler_byte(), 1'b0);
      end else begin
        // Stray close that the generator does not pop for.
        push_char(nesting_tracker::close_byte(2'($urandom_range(0, 2))), 1'b0);
      end
    end
    // Broken texts sometimes leave openers behind on purpose.
    if (flavor != TEXT_BROKEN || $urandom_range(0, 1) == 0) begin
      while (opened.size() > 0) begin
        t = opened[opened.size() - 1];
        opened.delete(opened.size() - 1);
        push_char(nesting_tracker::close_byte(t), 1'b0);
      end
    end
    push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Main stimulus.
  initial begin
    int unsigned pick;
    tracker           = new();
    items_counted     = 0;
    burst_left        = $urandom_range(1, 20);
    in_if.valid       = 1'b0;
    in_if.char_code   = 8'd0;
    in_if.end_of_text = 1'b0;
    rst_ni            = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty text, clean nesting, unmatched, mismatch, unclosed, ignored bytes.
    push_char(8'hFF, 1'b1);
    push_char(CHAR_BRACE_O, 1'b0);
    push_char(CHAR_PAREN_O, 1'b0);
    push_char(CHAR_SQUARE_O, 1'b0);
    push_char(CHAR_SQUARE_C, 1'b0);
    push_char(CHAR_PAREN_C, 1'b0);
    push_char(CHAR_BRACE_C, 1'b0);
    push_char(CHAR_LF, 1'b0);
    push_char(8'h00, 1'b1);
    push_char(CHAR_BRACE_C, 1'b0);
    push_char(CHAR_LF, 1'b0);
    push_char(CHAR_PAREN_O, 1'b0);
    push_char(CHAR_SQUARE_C, 1'b0);
    push_char(CHAR_SQUARE_O, 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'h55, 1'b1);
    wait_drain();

    // Random texts, mostly well-formed; the margin leaves room for the tail.
    while (items_counted + ITEM_MARGIN < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      gen_text(TEXT_CLEAN);
      else if (pick < 75) gen_text(TEXT_BROKEN);
      else if (pick < 85) gen_text(TEXT_DEEP);
      else                gen_text(TEXT_NOISE);
      if ($urandom_range(0, 11) == 0) wait_drain();
    end
    // Trailing noise without an end mark, then one final text.
    repeat (5) push_char(8'($urandom_range(0, 255)), 1'b0);
    gen_text(TEXT_CLEAN);

    wait_drain();
    if (tracker.owed_reports.size() != 0) begin
      $error("%0d reports never arrived", tracker.owed_reports.size());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("bracket_balance_checker_top test passed");
    end else begin
      $display("bracket_balance_checker_top test failed");
    end
    $finish;
  end

endmodule

>>> bracket_balance_checker_top.f
sv/bbc_pkg.sv
sv/bbc_in_if.sv
sv/bbc_out_if.sv
sv/bracket_balance_checker_top.sv
dv/bracket_balance_checker_top_tb.sv
